// File: src/modq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modq_pkg: shared types and constants for the modular vector ALU
// Word layouts for the operand and result channels, operation codes,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package modq_pkg;

    // lane geometry fixed by the packed word format
    localparam int COEFF_BITS = 16;
    localparam int PACK_LANES = 4;
    localparam int PACKS      = 4;
    localparam int PACK_BITS  = COEFF_BITS * PACK_LANES;
    localparam int SLOTS      = PACK_LANES * PACKS;

    // configuration register widths
    localparam int MOD_BITS   = 15;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [1:0] t_kind;

    // operation codes
    localparam t_kind KIND_ADD  = 2'd0;
    localparam t_kind KIND_SUB  = 2'd1;
    localparam t_kind KIND_MUL  = 2'd2;
    localparam t_kind KIND_RSVD = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS_INV = 2'd1;

    // reset values: q = 3329, q^-1 mod 2^16 = -3327
    localparam logic [MOD_BITS-1:0]   MODULUS_RST     = 15'd3329;
    localparam logic [COEFF_BITS-1:0] MODULUS_INV_RST = 16'hF301;

    // operand word
    typedef struct packed {
        t_kind                kind;
        logic [PACK_BITS-1:0] a_pack_0;
        logic [PACK_BITS-1:0] a_pack_1;
        logic [PACK_BITS-1:0] a_pack_2;
        logic [PACK_BITS-1:0] a_pack_3;
        logic [PACK_BITS-1:0] b_pack_0;
        logic [PACK_BITS-1:0] b_pack_1;
        logic [PACK_BITS-1:0] b_pack_2;
        logic [PACK_BITS-1:0] b_pack_3;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [PACK_BITS-1:0] r_pack_0;
        logic [PACK_BITS-1:0] r_pack_1;
        logic [PACK_BITS-1:0] r_pack_2;
        logic [PACK_BITS-1:0] r_pack_3;
    } t_out_word;

    // per-lane pipeline control
    typedef struct packed {
        logic  en_s1;
        logic  en_s2;
        t_kind kind_in;
        t_kind kind_s2;
    } t_lane_ctl;

endpackage

// File: src/modq_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modq_lane: one coefficient lane
// Modular add and subtract in the first stage; Montgomery multiply split
// over three multiplies, one per stage, with the result selected at the end.
// ----------------------------------------------------------------------------
module modq_lane (
    input  logic                                i_clk,
    input  modq_pkg::t_lane_ctl                 i_ctl,
    input  logic [modq_pkg::COEFF_BITS-1:0]     i_a,
    input  logic [modq_pkg::COEFF_BITS-1:0]     i_b,
    input  logic [modq_pkg::MOD_BITS-1:0]       i_modulus,
    input  logic [modq_pkg::COEFF_BITS-1:0]     i_modulus_inv,
    output logic [modq_pkg::COEFF_BITS-1:0]     o_res
);

    logic [modq_pkg::COEFF_BITS-1:0]   w_q16;
    logic [modq_pkg::COEFF_BITS-1:0]   w_sum;
    logic [modq_pkg::COEFF_BITS-1:0]   w_diff;
    logic                              w_sum_ge_q;
    logic [modq_pkg::COEFF_BITS-1:0]   w_add;
    logic [modq_pkg::COEFF_BITS-1:0]   w_sub;
    logic signed [2*modq_pkg::COEFF_BITS-1:0] w_prod;
    logic [2*modq_pkg::COEFF_BITS-1:0] w_tfull;
    logic signed [2*modq_pkg::COEFF_BITS-1:0] w_tq;
    logic [2*modq_pkg::COEFF_BITS-1:0] w_u;

    logic signed [2*modq_pkg::COEFF_BITS-1:0] r_p1;
    logic [modq_pkg::COEFF_BITS-1:0]   r_as1;
    logic [2*modq_pkg::COEFF_BITS-1:0] r_p2;
    logic [modq_pkg::COEFF_BITS-1:0]   r_t2;
    logic [modq_pkg::COEFF_BITS-1:0]   r_as2;

    // add: subtract q once when the wrapped sum is at least q
    assign w_q16      = {1'b0, i_modulus};
    assign w_sum      = i_a + i_b;
    assign w_sum_ge_q = $signed({w_sum[modq_pkg::COEFF_BITS-1], w_sum})
                        >= $signed({2'b00, i_modulus});
    assign w_add      = w_sum_ge_q ? (w_sum - w_q16) : w_sum;

    // subtract: add q once when the wrapped difference is negative
    assign w_diff = i_a - i_b;
    assign w_sub  = w_diff[modq_pkg::COEFF_BITS-1] ? (w_diff + w_q16) : w_diff;

    // full signed product of the operands
    assign w_prod = $signed(i_a) * $signed(i_b);

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s1) begin
            r_p1  <= w_prod;
            r_as1 <= (i_ctl.kind_in == modq_pkg::KIND_SUB) ? w_sub : w_add;
        end
    end

    // montgomery factor t = low16(low16(p) * qinv)
    assign w_tfull = r_p1[modq_pkg::COEFF_BITS-1:0] * i_modulus_inv;

    // stage 2
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s2) begin
            r_p2  <= r_p1;
            r_t2  <= w_tfull[modq_pkg::COEFF_BITS-1:0];
            r_as2 <= r_as1;
        end
    end

    // reduction: (p - t*q) >> 16, the upper half of the wrapped difference
    assign w_tq = $signed(r_t2) * $signed({1'b0, w_q16[modq_pkg::MOD_BITS-1:0]});
    assign w_u  = r_p2 - w_tq;

    // result select
    always_comb begin
        case (i_ctl.kind_s2) inside
            modq_pkg::KIND_ADD,
            modq_pkg::KIND_SUB: o_res = r_as2;
            modq_pkg::KIND_MUL: o_res = w_u[2*modq_pkg::COEFF_BITS-1:modq_pkg::COEFF_BITS];
            default:            o_res = '0;
        endcase
    end

endmodule

// File: src/modq_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modq_merge: lane merge and output register
// Gathers the lane results into the packed result word, zeroes the slots
// that have no lane, and holds the word for the receiver.
// ----------------------------------------------------------------------------
module modq_merge #(
    parameter int NLANES = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  logic [NLANES-1:0][modq_pkg::COEFF_BITS-1:0] i_res,
    output modq_pkg::t_out_word                         o_out
);

    logic [modq_pkg::SLOTS-1:0][modq_pkg::COEFF_BITS-1:0] w_slots;
    logic [modq_pkg::SLOTS*modq_pkg::COEFF_BITS-1:0]      w_flat;
    modq_pkg::t_out_word                                  n_out;
    modq_pkg::t_out_word                                  r_out;

    // place each lane in its slot, empty slots read zero
    for (genvar g = 0; g < modq_pkg::SLOTS; g++) begin : g_slot
        if (g < NLANES) begin : g_used
            assign w_slots[g] = i_res[g];
        end else begin : g_empty
            assign w_slots[g] = '0;
        end
    end

    // split into the four pack fields, lane 0 lowest
    assign w_flat = w_slots;
    always_comb begin
        n_out.r_pack_0 = w_flat[1*modq_pkg::PACK_BITS-1:0];
        n_out.r_pack_1 = w_flat[2*modq_pkg::PACK_BITS-1:1*modq_pkg::PACK_BITS];
        n_out.r_pack_2 = w_flat[3*modq_pkg::PACK_BITS-1:2*modq_pkg::PACK_BITS];
        n_out.r_pack_3 = w_flat[4*modq_pkg::PACK_BITS-1:3*modq_pkg::PACK_BITS];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

// File: src/modq_vector_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modq_vector_alu: lane-wise modular arithmetic on coefficient vectors
// Sixteen signed 16-bit lanes per word: modular add, modular subtract or
// Montgomery multiply, all lanes side by side.
// ----------------------------------------------------------------------------
// Usage:
//   Operand words enter on i_valid / o_ready with the operation kind and
//   both operand vectors in i_in. Result words leave on o_valid / i_ready
//   in o_out, in the order the operands were taken.
//   Configuration writes arrive on i_cfg_valid / o_cfg_ready; index 0 sets
//   the modulus q, index 1 sets q^-1 mod 2^16. o_cfg_ready is always high.
//   Write them only while no word is in flight.
//   An accepted word passes the two lane stages, then the output register,
//   before o_valid. Throughput: one word per cycle while results are taken;
//   the three multiplies of the Montgomery path each own a stage of every lane.
//   Reset empties the pipeline and loads q = 3329, q^-1 = -3327.
//   When the receiver stalls, the result word is held and words behind it
//   keep moving into empty stages; o_ready drops only once every stage is
//   full and the output is not being taken.
// ----------------------------------------------------------------------------
module modq_vector_alu #(
    parameter int LANES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // operand channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  modq_pkg::t_in_word                    i_in,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output modq_pkg::t_out_word                   o_out,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [modq_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [modq_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int NLANES = (LANES < modq_pkg::SLOTS) ? LANES : modq_pkg::SLOTS;

    logic [modq_pkg::MOD_BITS-1:0]   r_modulus;
    logic [modq_pkg::COEFF_BITS-1:0] r_modulus_inv;
    logic                            r_v1;
    logic                            r_v2;
    logic                            r_vo;
    modq_pkg::t_kind                 r_kind1;
    modq_pkg::t_kind                 r_kind2;

    logic                            w_en_s1;
    logic                            w_en_s2;
    logic                            w_adv_o;
    modq_pkg::t_lane_ctl             w_ctl;
    logic [modq_pkg::SLOTS*modq_pkg::COEFF_BITS-1:0] w_a_flat;
    logic [modq_pkg::SLOTS*modq_pkg::COEFF_BITS-1:0] w_b_flat;
    logic [NLANES-1:0][modq_pkg::COEFF_BITS-1:0]     w_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus     <= modq_pkg::MODULUS_RST;
            r_modulus_inv <= modq_pkg::MODULUS_INV_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                modq_pkg::CFG_MODULUS:
                    r_modulus <= i_cfg_data[modq_pkg::MOD_BITS-1:0];
                modq_pkg::CFG_MODULUS_INV:
                    r_modulus_inv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance: each stage moves when it holds a word and the next has room
    assign w_adv_o = r_v2 && (!r_vo || i_ready);
    assign w_en_s2 = r_v1 && (!r_v2 || w_adv_o);
    assign o_ready = !r_v1 || w_en_s2;
    assign w_en_s1 = i_valid && o_ready;

    // occupancy of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en_s1) begin
                r_v1 <= 1'b1;
            end else if (w_en_s2) begin
                r_v1 <= 1'b0;
            end
            if (w_en_s2) begin
                r_v2 <= 1'b1;
            end else if (w_adv_o) begin
                r_v2 <= 1'b0;
            end
            if (w_adv_o) begin
                r_vo <= 1'b1;
            end else if (i_ready) begin
                r_vo <= 1'b0;
            end
        end
    end

    // operation kind travels beside the lane data
    always_ff @(posedge i_clk) begin
        if (w_en_s1) begin
            r_kind1 <= i_in.kind;
        end
        if (w_en_s2) begin
            r_kind2 <= r_kind1;
        end
    end

    assign w_ctl.en_s1   = w_en_s1;
    assign w_ctl.en_s2   = w_en_s2;
    assign w_ctl.kind_in = i_in.kind;
    assign w_ctl.kind_s2 = r_kind2;

    // unpack the operand vectors, lane 0 lowest
    assign w_a_flat = {i_in.a_pack_3, i_in.a_pack_2, i_in.a_pack_1, i_in.a_pack_0};
    assign w_b_flat = {i_in.b_pack_3, i_in.b_pack_2, i_in.b_pack_1, i_in.b_pack_0};

    // lanes
    for (genvar g = 0; g < NLANES; g++) begin : g_lane
        modq_lane u_lane (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_a           (w_a_flat[g*modq_pkg::COEFF_BITS +: modq_pkg::COEFF_BITS]),
            .i_b           (w_b_flat[g*modq_pkg::COEFF_BITS +: modq_pkg::COEFF_BITS]),
            .i_modulus     (r_modulus),
            .i_modulus_inv (r_modulus_inv),
            .o_res         (w_res[g])
        );
    end

    // merge and output register
    modq_merge #(
        .NLANES (NLANES)
    ) u_merge (
        .i_clk (i_clk),
        .i_en  (w_adv_o),
        .i_res (w_res),
        .o_out (o_out)
    );

    assign o_valid = r_vo;

`ifndef ASSERT_OFF
    // the input side only stalls when every stage is full and the output is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_vo && !i_ready))
        else $error("input stalled with room in the pipeline");

    // a word in stage one that cannot move stays put
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_en_s2) |=> r_v1)
        else $error("stage one word lost");

    // a word in stage two that cannot move stays put
    a_s2_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_adv_o) |=> r_v2)
        else $error("stage two word lost");

    // the reserved kind leaves an all-zero result word
    a_rsvd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv_o && r_kind2 == modq_pkg::KIND_RSVD) |=> (o_out == '0))
        else $error("reserved kind gave a non-zero result");
`endif

endmodule
